>>> sv/trc_pkg.sv
// ---------------------------------------------------------------------------
// trc_pkg: shared types and constants for the tag route cache
// Table size, payload structs, token and write-port structs, code values.
// ---------------------------------------------------------------------------
package trc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int KEY_W = 64;
	localparam int WH_W  = 8;
	localparam int SC_W  = 24;
	localparam int ANG_W = 8;

	// reply classes
	localparam logic [1:0] CL_GOOD     = 2'd0;
	localparam logic [1:0] CL_PARSE    = 2'd1;
	localparam logic [1:0] CL_NOTFOUND = 2'd2;
	localparam logic [1:0] CL_OTHER    = 2'd3;

	// route status codes
	localparam logic [1:0] ST_SERVER  = 2'd0;
	localparam logic [1:0] ST_HIT     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_WAREHOUSE  = 2'd0;
	localparam logic [1:0] REG_STORE_CODE = 2'd1;
	localparam logic [1:0] REG_ANGLE      = 2'd2;

	localparam logic [WH_W-1:0]  RST_WAREHOUSE  = 8'd2;
	localparam logic [SC_W-1:0]  RST_STORE_CODE = 24'd66;  // "B"
	localparam logic [ANG_W-1:0] RST_ANGLE      = 8'd90;

	typedef struct packed {
		logic [KEY_W-1:0] tag_key;
		logic             link_up;
		logic [1:0]       reply_class;
		logic [WH_W-1:0]  reply_warehouse;
		logic [SC_W-1:0]  reply_store_code;
		logic [ANG_W-1:0] reply_angle;
	} req_t;

	typedef struct packed {
		logic [1:0]       route_status;
		logic [WH_W-1:0]  warehouse;
		logic [SC_W-1:0]  store_code;
		logic [ANG_W-1:0] angle;
	} rsp_t;

	typedef struct packed {
		logic [WH_W-1:0]  warehouse;
		logic [SC_W-1:0]  store_code;
		logic [ANG_W-1:0] angle;
	} route_t;

	// search token walking down the cell chain
	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic             hit;
		logic [IDX_W-1:0] idx;
		route_t           route;
	} tok_t;

	// broadcast write into one cell
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
		route_t           route;
	} wr_t;

endpackage

>>> sv/trc_cell.sv
// ---------------------------------------------------------------------------
// trc_cell: one table entry of the route cache
// Holds a key and route, compares a passing search token against them and
// hands the token on to the next cell through a register.
// ---------------------------------------------------------------------------
module trc_cell import trc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [CNT_W-1:0] fill,
	input  wr_t              wr,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	logic [KEY_W-1:0] key_q;
	route_t           route_q;
	tok_t             tok_q;
	tok_t             tok_nxt;
	logic             live;

	// entries below the fill count hold real data
	assign live = CNT_W'(cell_idx) < fill;

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.vld && !tok_in.hit && live && key_q == tok_in.key) begin
			tok_nxt.hit   = 1'b1;
			tok_nxt.idx   = cell_idx;
			tok_nxt.route = route_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == cell_idx) begin
			key_q   <= wr.key;
			route_q <= wr.route;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.vld <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> sv/tag_route_cache_fallback.sv
// ---------------------------------------------------------------------------
// tag_route_cache_fallback: fully associative route cache with default route
// A new request is taken only while idle: the search token walks the chain
// of ENTRIES cells, one cell per cycle, the hit result is registered, then
// the result register and the write-back follow once the output is free.
// Reset: fill count and replace pointer clear, defaults load 2 / "B" / 90;
// entry storage is not cleared, entries at or above the fill count are never used.
// ---------------------------------------------------------------------------
module tag_route_cache_fallback import trc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic             busy_q;
	logic             pend_q;
	req_t             req_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	route_t           hit_route_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] ptr_q;
	route_t           dflt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	tok_t             chain [ENTRIES+1];
	tok_t             tok_last;
	wr_t              wr;
	logic             req_fire;
	logic             out_free;
	logic             finish;
	logic             good;
	logic             not_found;
	logic             full;
	rsp_t             rsp_nxt;

	assign req_fire  = req_valid && !req_stall;
	assign req_stall = busy_q;
	assign cfg_ready = 1'b1;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = pend_q && out_free;
	assign tok_last  = chain[ENTRIES];

	always_comb begin
		chain[0]       = '0;
		chain[0].vld   = req_fire;
		chain[0].key   = req.tag_key;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		trc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.fill     (fill_q),
			.wr       (wr),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	assign good      = req_q.link_up && req_q.reply_class == CL_GOOD;
	assign not_found = req_q.link_up && req_q.reply_class == CL_NOTFOUND;
	assign full      = fill_q == CNT_W'(ENTRIES);

	// write-back of a good reply: update on hit, else fill the next free slot, else replace in order
	always_comb begin
		wr.en             = finish && good;
		wr.key            = req_q.tag_key;
		wr.route.warehouse  = req_q.reply_warehouse;
		wr.route.store_code = req_q.reply_store_code;
		wr.route.angle      = req_q.reply_angle;
		if (hit_q) begin
			wr.idx = hit_idx_q;
		end else if (!full) begin
			wr.idx = fill_q[IDX_W-1:0];
		end else begin
			wr.idx = ptr_q;
		end
	end

	always_comb begin
		if (good) begin
			rsp_nxt.route_status = ST_SERVER;
			rsp_nxt.warehouse    = req_q.reply_warehouse;
			rsp_nxt.store_code   = req_q.reply_store_code;
			rsp_nxt.angle        = req_q.reply_angle;
		end else if (not_found) begin
			rsp_nxt.route_status = ST_UNKNOWN;
			rsp_nxt.warehouse    = dflt_q.warehouse;
			rsp_nxt.store_code   = dflt_q.store_code;
			rsp_nxt.angle        = dflt_q.angle;
		end else if (hit_q) begin
			rsp_nxt.route_status = ST_HIT;
			rsp_nxt.warehouse    = hit_route_q.warehouse;
			rsp_nxt.store_code   = hit_route_q.store_code;
			rsp_nxt.angle        = hit_route_q.angle;
		end else begin
			rsp_nxt.route_status = ST_NONE;
			rsp_nxt.warehouse    = dflt_q.warehouse;
			rsp_nxt.store_code   = dflt_q.store_code;
			rsp_nxt.angle        = dflt_q.angle;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (tok_last.vld) begin
			hit_q       <= tok_last.hit;
			hit_idx_q   <= tok_last.idx;
			hit_route_q <= tok_last.route;
		end
		if (finish) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			fill_q      <= '0;
			ptr_q       <= '0;
			dflt_q.warehouse  <= RST_WAREHOUSE;
			dflt_q.store_code <= RST_STORE_CODE;
			dflt_q.angle      <= RST_ANGLE;
		end else begin
			if (req_fire) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end

			if (tok_last.vld) begin
				pend_q <= 1'b1;
			end else if (finish) begin
				pend_q <= 1'b0;
			end

			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (wr.en && !hit_q) begin
				if (!full) begin
					fill_q <= fill_q + CNT_W'(1);
				end else if (ptr_q == IDX_W'(ENTRIES - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAREHOUSE:  dflt_q.warehouse  <= cfg_data[WH_W-1:0];
					REG_STORE_CODE: dflt_q.store_code <= cfg_data[SC_W-1:0];
					REG_ANGLE:      dflt_q.angle      <= cfg_data[ANG_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// token leaves the chain only for an item in flight that has not finished yet
	a_tok_exit: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.vld |-> busy_q && !pend_q)
		else $error("search token left chain with no item in flight");

	// no new request while a write-back is pending or a search token leaves the chain
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> !pend_q && !tok_last.vld)
		else $error("request accepted during search");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond table size");

	// replacement pointer advances only once the table is full
	a_ptr_full: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ptr_q) |-> $past(full))
		else $error("replace pointer moved before table full");

	// each finished item produces a result on the next cycle
	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp_valid && !busy_q)
		else $error("finished item did not produce a result");

endmodule
